// ===== hdl/tmtaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtaf_pkg
// shared types, constants and the cordic arctangent table of the tilt filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmtaf_pkg;

  localparam int CORNER_W  = 14;
  localparam int SUM_W     = 16;
  localparam int TIME_W    = 32;
  localparam int WEIGHT_W  = 17;
  localparam int ANG_W     = 15;
  localparam int SMOOTH_W  = 24;
  localparam int XW        = 28;
  localparam int ZW        = 26;
  localparam int TBL_IDX_W = 5;
  localparam int ATAN_W    = 22;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 32;

  localparam logic signed [ANG_W-1:0]   LIMIT_Q88  = 15'sd11520;
  localparam logic [WEIGHT_W-1:0]       WEIGHT_ONE = 17'd65536;

  localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING_WEIGHT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_UPDATE_TICKS = 1'b1;

  typedef struct packed {
    logic load_in;
    logic store_first;
    logic setup;
    logic rotate;
    logic round;
    logic mul;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic slot;
    logic special;
    logic iter_done;
    logic due;
  } sts_t;

  // atan(2^-i) in q16 degrees
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tmtaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmtaf_ctrl
// sequencer for the tilt filter: request handshakes, cordic loop, filter steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtaf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tmtaf_pkg::sts_t   sts,
  output tmtaf_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ROT,
    S_ROUND,
    S_CHECK,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.slot) begin
          cmd.store_first = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = sts.special ? S_CHECK : S_ROT;
        end
      end
      S_ROT: begin
        if (sts.iter_done) begin
          state_nxt = S_ROUND;
        end else begin
          cmd.rotate = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.mul   = sts.due;
        state_nxt = sts.due ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/tmtaf_dp.sv =====
// ----------------------------------------------------------------------------
// tmtaf_dp
// datapath: corner sums, marker ordering, iterative cordic, low-pass filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmtaf_dp #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tmtaf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tmtaf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [tmtaf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,
  output logic [tmtaf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tuser,
  input  tmtaf_pkg::cmd_t                      cmd,
  output tmtaf_pkg::sts_t                      sts
);

  localparam int CW  = tmtaf_pkg::CORNER_W;
  localparam int SW  = tmtaf_pkg::SUM_W;
  localparam int TW  = tmtaf_pkg::TIME_W;
  localparam int WW  = tmtaf_pkg::WEIGHT_W;
  localparam int AW  = tmtaf_pkg::ANG_W;
  localparam int MW  = tmtaf_pkg::SMOOTH_W;
  localparam int XW  = tmtaf_pkg::XW;
  localparam int ZW  = tmtaf_pkg::ZW;
  localparam int IXW = tmtaf_pkg::TBL_IDX_W;
  localparam int IW  = $clog2(CORDIC_STEPS + 1);
  localparam int P1W = WW + 1 + AW + 8;
  localparam int P2W = WW + 1 + MW;
  localparam int SMW = P2W + 2;

  // configuration
  logic [WW-1:0] weight_r;
  logic [TW-1:0] min_ticks_r;

  // request capture
  logic [SW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic [TW-1:0] time_r;
  logic          slot_r;

  // model state
  logic [SW-1:0]        first_x_r, first_y_r;
  logic signed [MW-1:0] s_r;
  logic                 seeded_r;
  logic [TW-1:0]        last_r;

  // working registers
  logic signed [XW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic [IW-1:0]         iter_r;
  logic signed [AW-1:0]  raw_r;
  logic                  clamped_r;
  logic signed [P1W-1:0] p1_r;
  logic signed [P2W-1:0] p2_r;

  // output registers
  logic signed [AW-1:0] o_filt_r, o_raw_r;
  logic                 o_clamp_r;

  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      sx_nxt = sx_nxt + {{(SW-CW){1'b0}}, in_tdata[2*k*CW +: CW]};
      sy_nxt = sy_nxt + {{(SW-CW){1'b0}}, in_tdata[(2*k+1)*CW +: CW]};
    end
  end

  // ordering and steep-case detection
  logic                  cur_right;
  logic [SW-1:0]         rx, lx, ry, ly, dx;
  logic signed [SW:0]    dy;
  logic [SW:0]           ady;
  logic                  zero_d, steep;
  logic signed [AW-1:0]  spec_raw;
  logic                  spec_clamp;

  always_comb begin
    cur_right = first_x_r < sx_r;
    rx        = cur_right ? sx_r : first_x_r;
    lx        = cur_right ? first_x_r : sx_r;
    ry        = cur_right ? sy_r : first_y_r;
    ly        = cur_right ? first_y_r : sy_r;
    dx        = rx - lx;
    dy        = $signed({1'b0, ry}) - $signed({1'b0, ly});
    ady       = dy[SW] ? 17'(-dy) : 17'(dy);
    zero_d    = (dx == '0) && (dy == '0);
    steep     = ady >= {1'b0, dx};
    spec_clamp = !zero_d && (ady > {1'b0, dx});
    if (zero_d) begin
      spec_raw = '0;
    end else if (dy[SW]) begin
      spec_raw = tmtaf_pkg::LIMIT_Q88;
    end else begin
      spec_raw = -tmtaf_pkg::LIMIT_Q88;
    end
  end

  // one cordic rotation
  logic signed [XW-1:0] xs, ys, x_rot, y_rot;
  logic signed [ZW-1:0] z_rot, at;

  always_comb begin
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    at = $signed({{(ZW-tmtaf_pkg::ATAN_W){1'b0}}, tmtaf_pkg::atan_q16(IXW'(iter_r))});
    if (!y_r[XW-1]) begin
      x_rot = x_r + ys;
      y_rot = y_r - xs;
      z_rot = z_r + at;
    end else begin
      x_rot = x_r - ys;
      y_rot = y_r + xs;
      z_rot = z_r - at;
    end
  end

  // rounding and clamp
  logic signed [ZW-1:0] zr;
  logic signed [AW-1:0] z_clamped;

  always_comb begin
    zr = (z_r + ZW'(128)) >>> 8;
    if (zr > ZW'(tmtaf_pkg::LIMIT_Q88)) begin
      z_clamped = tmtaf_pkg::LIMIT_Q88;
    end else if (zr < -ZW'(tmtaf_pkg::LIMIT_Q88)) begin
      z_clamped = -tmtaf_pkg::LIMIT_Q88;
    end else begin
      z_clamped = AW'(zr);
    end
  end

  // filter
  logic [WW-1:0]         w_sat, w_comp;
  logic signed [SMW-1:0] fsum;
  logic signed [MW:0]    s_rnd;
  logic [TW-1:0]         elapsed;

  always_comb begin
    w_sat   = (weight_r > tmtaf_pkg::WEIGHT_ONE) ? tmtaf_pkg::WEIGHT_ONE : weight_r;
    w_comp  = tmtaf_pkg::WEIGHT_ONE - w_sat;
    fsum    = {{(SMW-P1W){p1_r[P1W-1]}}, p1_r} + {{(SMW-P2W){p2_r[P2W-1]}}, p2_r}
              + SMW'(32768);
    s_rnd   = {s_r[MW-1], s_r} + (MW+1)'(128);
    elapsed = time_r - last_r;
  end

  always_comb begin
    sts.slot      = slot_r;
    sts.special   = zero_d || steep;
    sts.iter_done = (iter_r == IW'(CORDIC_STEPS));
    sts.due       = elapsed >= min_ticks_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= 17'd9830;
      min_ticks_r <= '0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      s_r         <= '0;
      seeded_r    <= 1'b0;
      last_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          tmtaf_pkg::CFG_SMOOTHING_WEIGHT: weight_r    <= cfg_wdata[WW-1:0];
          tmtaf_pkg::CFG_MIN_UPDATE_TICKS: min_ticks_r <= cfg_wdata[TW-1:0];
          default: ;
        endcase
      end
      if (cmd.store_first) begin
        first_x_r <= sx_r;
        first_y_r <= sy_r;
      end
      if (cmd.acc) begin
        if (!seeded_r) begin
          s_r <= {raw_r[AW-1], raw_r, 8'b0};
        end else begin
          s_r <= fsum[MW+15:16];
        end
        seeded_r <= 1'b1;
        last_r   <= time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      time_r <= in_tdata[8*CW +: TW];
      slot_r <= in_tuser;
    end
    if (cmd.setup) begin
      x_r       <= $signed({{(XW-SW-8){1'b0}}, dx, 8'b0});
      y_r       <= -$signed({{(XW-SW-9){dy[SW]}}, dy, 8'b0});
      z_r       <= '0;
      iter_r    <= '0;
      raw_r     <= spec_raw;
      clamped_r <= spec_clamp;
    end
    if (cmd.rotate) begin
      x_r    <= x_rot;
      y_r    <= y_rot;
      z_r    <= z_rot;
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.round) begin
      raw_r <= z_clamped;
    end
    if (cmd.mul) begin
      p1_r <= $signed({1'b0, w_sat}) * $signed({raw_r, 8'b0});
      p2_r <= $signed({1'b0, w_comp}) * s_r;
    end
    if (cmd.emit) begin
      o_filt_r  <= s_rnd[AW+7:8];
      o_raw_r   <= raw_r;
      o_clamp_r <= clamped_r;
    end
  end

  assign out_tdata = {{(tmtaf_pkg::OUT_DATA_W-2*AW){1'b0}}, o_raw_r, o_filt_r};
  assign out_tuser = o_clamp_r;

endmodule

// ===== hdl/two_marker_tilt_angle_filter.sv =====
// ----------------------------------------------------------------------------
// two_marker_tilt_angle_filter
// flow: a slot 0 request only stores the first marker; a slot 1 request runs
//   setup, cordic rotation and rounding (skipped if steep or coincident), a due
//   check, accumulate, emit (nothing if not due); requests are taken only in idle
// the single shared cordic rotator steps one iteration per cycle
// reset: rst_n synchronous active low, clears filter state and loads defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_marker_tilt_angle_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tmtaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tmtaf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, time_now
  input  logic [tmtaf_pkg::IN_DATA_W-1:0]  in_tdata,
  // marker_slot
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // filtered_angle, raw_angle, zero pad
  output logic [tmtaf_pkg::OUT_DATA_W-1:0] out_tdata,
  // was_clamped
  output logic                             out_tuser
);

  tmtaf_pkg::cmd_t cmd;
  tmtaf_pkg::sts_t sts;

  tmtaf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tmtaf_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
